FILE: sv/iff_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the integer field formatter.
// Depends on nothing; the controller, datapath, top level and bench refer to it by scoped names.
package iff_pkg;

  // Conversion selector codes
  typedef enum logic [2:0] {
    ACT_SDEC = 3'd0,
    ACT_UDEC = 3'd1,
    ACT_OCT  = 3'd2,
    ACT_LHEX = 3'd3,
    ACT_UHEX = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_TRIM,
    S_FILL_PRE,
    S_SIGN,
    S_DIGIT,
    S_FILL_POST
  } state_t;

  // Which character the output register takes this cycle
  typedef enum logic [1:0] {
    EM_NONE,
    EM_FILL,
    EM_SIGN,
    EM_DIGIT
  } emit_t;

  typedef struct packed {
    logic  load;
    logic  conv_step;
    logic  trim_step;
    logic  fill_load;
    emit_t emit;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic act_ok;
    logic dec;
    logic conv_done;
    logic trim_done;
    logic neg;
    logic left;
    logic fill_zero;
    logic fill_one;
    logic dig_one;
    logic init_fill_zero;
  } status_t;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_MINUS = 7'h2D;

  localparam logic [6:0] UPPER_DIGITS [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
  };
  localparam logic [6:0] LOWER_DIGITS [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
  };

endpackage

FILE: sv/iff_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the integer field formatter.
// Depends on iff_pkg; drives the datapath through cmd_t, reads status_t.
module iff_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  iff_pkg::status_t status,
  output iff_pkg::cmd_t    cmd,
  output logic             busy
);

  iff_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iff_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      iff_pkg::S_IDLE: begin
        if (start && status.act_ok) state_next = iff_pkg::S_CONV;
      end
      iff_pkg::S_CONV: begin
        if (!status.dec || status.conv_done) state_next = iff_pkg::S_TRIM;
      end
      iff_pkg::S_TRIM: begin
        if (status.trim_done) begin
          if (!status.left && !status.init_fill_zero) state_next = iff_pkg::S_FILL_PRE;
          else if (status.neg)                        state_next = iff_pkg::S_SIGN;
          else                                        state_next = iff_pkg::S_DIGIT;
        end
      end
      iff_pkg::S_FILL_PRE: begin
        if (status.fill_one) state_next = status.neg ? iff_pkg::S_SIGN : iff_pkg::S_DIGIT;
      end
      iff_pkg::S_SIGN: begin
        state_next = iff_pkg::S_DIGIT;
      end
      iff_pkg::S_DIGIT: begin
        if (status.dig_one) begin
          if (status.left && !status.fill_zero) state_next = iff_pkg::S_FILL_POST;
          else                                  state_next = iff_pkg::S_IDLE;
        end
      end
      iff_pkg::S_FILL_POST: begin
        if (status.fill_one) state_next = iff_pkg::S_IDLE;
      end
      default: state_next = iff_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '{load: 1'b0, conv_step: 1'b0, trim_step: 1'b0, fill_load: 1'b0,
             emit: iff_pkg::EM_NONE, last: 1'b0};
    busy = 1'b1;
    unique case (state)
      iff_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start && status.act_ok;
      end
      iff_pkg::S_CONV: begin
        cmd.conv_step = status.dec && !status.conv_done;
      end
      iff_pkg::S_TRIM: begin
        cmd.fill_load = status.trim_done;
        cmd.trim_step = !status.trim_done;
      end
      iff_pkg::S_FILL_PRE: begin
        cmd.emit = iff_pkg::EM_FILL;
      end
      iff_pkg::S_SIGN: begin
        cmd.emit = iff_pkg::EM_SIGN;
      end
      iff_pkg::S_DIGIT: begin
        cmd.emit = iff_pkg::EM_DIGIT;
        cmd.last = status.dig_one && (!status.left || status.fill_zero);
      end
      iff_pkg::S_FILL_POST: begin
        cmd.emit = iff_pkg::EM_FILL;
        cmd.last = status.fill_one;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

FILE: sv/iff_dp.sv
`timescale 1ns / 1ps
// Datapath of the integer field formatter: digit register, shift-and-add-3
// decimal conversion, counters and the registered character output. Uses iff_pkg.
module iff_dp #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_WIDTH  = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [2:0]       action,
  input  logic [31:0]      value,
  input  logic [6:0]       field_width,
  input  logic             left_justify,
  input  logic             zero_fill,
  input  iff_pkg::cmd_t    cmd,
  output iff_pkg::status_t status,
  output logic [6:0]       character,
  output logic             last,
  output logic             strobe
);

  localparam int ND = (VALUE_BITS + 2) / 3;   // digit slots, enough for any base
  localparam int DW = ND * 4;
  localparam int OW = ND * 3;
  localparam int NW = $clog2(ND + 1);
  localparam int CW = $clog2(VALUE_BITS + 1);
  localparam int VW = (VALUE_BITS > 32) ? VALUE_BITS : 32;

  logic [DW-1:0]         dig;
  logic [VALUE_BITS-1:0] bin;
  logic [CW-1:0]         cnt;
  logic [NW-1:0]         ndig;
  logic [6:0]            nfill;
  logic [6:0]            width;
  logic                  neg, left, zero, upper, dec;

  logic [VW-1:0]         val_ext;
  logic [VALUE_BITS-1:0] mag_raw, mag_abs;
  logic                  in_neg;
  logic [OW-1:0]         oct_ext;
  logic [DW-1:0]         oct_pack, load_dig, dig_adj;
  logic [6:0]            count, fill_init;
  logic [3:0]            top;

  // Operand preparation at load
  always_comb begin
    val_ext = VW'(value);
    mag_raw = val_ext[VALUE_BITS-1:0];
    in_neg  = (action == iff_pkg::ACT_SDEC) && mag_raw[VALUE_BITS-1];
    mag_abs = in_neg ? (~mag_raw + VALUE_BITS'(1)) : mag_raw;
    oct_ext = OW'(mag_abs);
    for (int i = 0; i < ND; i++) begin
      oct_pack[4*i +: 4] = {1'b0, oct_ext[3*i +: 3]};
    end
    case (action) inside
      iff_pkg::ACT_OCT:                   load_dig = oct_pack;
      iff_pkg::ACT_LHEX, iff_pkg::ACT_UHEX: load_dig = DW'(mag_abs);
      default:                            load_dig = '0;
    endcase
  end

  // Add 3 to every BCD digit of five or more before the next shift
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      dig_adj[4*i +: 4] = (dig[4*i +: 4] >= 4'd5) ? dig[4*i +: 4] + 4'd3 : dig[4*i +: 4];
    end
  end

  always_comb begin
    top       = dig[DW-1 -: 4];
    count     = 7'(ndig) + 7'(neg);
    fill_init = (width > count) ? width - count : 7'd0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dig   <= load_dig;
      bin   <= mag_abs;
      cnt   <= '0;
      ndig  <= NW'(ND);
      width <= (field_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : field_width;
      neg   <= in_neg;
      left  <= left_justify;
      zero  <= zero_fill;
      upper <= (action == iff_pkg::ACT_UHEX);
      dec   <= (action == iff_pkg::ACT_SDEC) || (action == iff_pkg::ACT_UDEC);
    end else if (cmd.conv_step) begin
      dig <= {dig_adj[DW-2:0], bin[VALUE_BITS-1]};
      bin <= bin << 1;
      cnt <= cnt + CW'(1);
    end else if (cmd.trim_step || cmd.emit == iff_pkg::EM_DIGIT) begin
      dig  <= dig << 4;
      ndig <= ndig - NW'(1);
    end
    if (cmd.fill_load) begin
      nfill <= fill_init;
    end else if (cmd.emit == iff_pkg::EM_FILL) begin
      nfill <= nfill - 7'd1;
    end
  end

  // Registered character output
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (cmd.emit != iff_pkg::EM_NONE);
    end
  end

  always_ff @(posedge clk) begin
    last <= cmd.last;
    unique case (cmd.emit)
      iff_pkg::EM_FILL:  character <= zero ? iff_pkg::CH_ZERO : iff_pkg::CH_SPACE;
      iff_pkg::EM_SIGN:  character <= iff_pkg::CH_MINUS;
      iff_pkg::EM_DIGIT: character <= upper ? iff_pkg::UPPER_DIGITS[top]
                                            : iff_pkg::LOWER_DIGITS[top];
      default:           character <= character;
    endcase
  end

  always_comb begin
    status.act_ok         = (action <= iff_pkg::ACT_UHEX);
    status.dec            = dec;
    status.conv_done      = (cnt == CW'(VALUE_BITS));
    status.trim_done      = (ndig == NW'(1)) || (top != 4'd0);
    status.neg            = neg;
    status.left           = left;
    status.fill_zero      = (nfill == 7'd0);
    status.fill_one       = (nfill == 7'd1);
    status.dig_one        = (ndig == NW'(1));
    status.init_fill_zero = (fill_init == 7'd0);
  end

endmodule

FILE: sv/integer_field_formatter_core.sv
`timescale 1ns / 1ps
// Top level of the integer field formatter: controller plus datapath.
// Depends on iff_pkg, iff_ctrl and iff_dp.
//
// Usage: drive action, value, field_width, left_justify and zero_fill and
// raise start; the item is taken at a rising edge with start high and busy
// low. Busy stays high while the field is produced. Each character appears
// on character/last for exactly one cycle with strobe high; the receiver
// must take every beat, as there is no way to hold the block off. The last
// beat of a field carries last. An unknown action is taken and dropped:
// no beats follow and busy stays low.
//
// Sequence per item: for decimal, the conversion state runs one
// shift-and-add-3 step per bit of VALUE_BITS; octal and hex leave it at
// once. Leading zero digit slots are then stripped one at a time, and
// the field follows at one beat per cycle: max(field_width capped at
// MAX_WIDTH, digits + sign) characters. The decimal conversion loop and
// the single character output take most of the time of an item.
// Busy falls after the last beat is registered, so the next item may be
// taken in the same cycle the last beat shows.
// Reset (rst, synchronous) returns the controller to idle and drops strobe.
module integer_field_formatter_core #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_WIDTH  = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [31:0] value,
  input  logic [6:0]  field_width,
  input  logic        left_justify,
  input  logic        zero_fill,
  output logic        strobe,
  output logic [6:0]  character,
  output logic        last
);

  iff_pkg::cmd_t    cmd;
  iff_pkg::status_t status;

  // Sequencer: decides which datapath step runs each cycle
  iff_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Datapath: holds the item, converts, counts and registers each beat
  iff_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .action       (action),
    .value        (value),
    .field_width  (field_width),
    .left_justify (left_justify),
    .zero_fill    (zero_fill),
    .cmd          (cmd),
    .status       (status),
    .character    (character),
    .last         (last),
    .strobe       (strobe)
  );

endmodule

FILE: sv/iff_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the integer field formatter, bound to the top level.
// Depends only on the ports of integer_field_formatter_core.
module iff_chk (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       strobe,
  input logic       last
);

  // Reset drops any beat in flight
  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe)
    else $error("strobe seen after reset");

  // Beats of one field come in consecutive cycles
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("gap inside a field");

  // An unfinished field keeps the block busy
  a_busy_mid: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("busy low in the middle of a field");

  // Every beat was produced while the block was working
  a_beat_from_work: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("beat without preceding work");

endmodule

bind integer_field_formatter_core iff_chk u_iff_chk (
  .clk    (clk),
  .rst    (rst),
  .busy   (busy),
  .strobe (strobe),
  .last   (last)
);

FILE: verif/tb_integer_field_formatter_core.sv
`timescale 1ns / 1ps
// Self-checking bench for integer_field_formatter_core: predicts every character beat of
// each formatted field and checks the strobed output stream against it. Depends on iff_pkg.
module tb_integer_field_formatter_core;

  localparam int          MAX_FIELD   = 64;
  localparam logic [6:0]  CHR_LOWER_A = 7'h61;
  localparam logic [6:0]  CHR_UPPER_A = 7'h41;
  localparam int          FIELDS_RAND = 190;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } char_beat_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  action;
  logic [31:0] value;
  logic [6:0]  field_width;
  logic        left_justify;
  logic        zero_fill;
  logic        strobe;
  logic [6:0]  character;
  logic        last;

  char_beat_t  pending_beats[$];
  int          error_count  = 0;
  int          fields_sent  = 0;
  int          dropped_sent = 0;
  int          beats_seen   = 0;

  integer_field_formatter_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .value        (value),
    .field_width  (field_width),
    .left_justify (left_justify),
    .zero_fill    (zero_fill),
    .strobe       (strobe),
    .character    (character),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Even with every item as slow as the slowest kind plus a long gap, some 230 items
  // finish well within 5 ms, so the timeout leaves a wide margin.
  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d beats still awaited", $time, pending_beats.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic void push_char(input logic [6:0] ch);
    char_beat_t b;
    b.character = ch;
    b.last      = 1'b0;
    pending_beats.push_back(b);
  endfunction

  // Work out the characters of one field and queue them, last mark on the final one.
  function automatic void predict_field(input logic [2:0] act, input logic [31:0] val,
                                        input logic [6:0] fw, input logic lj,
                                        input logic zf);
    logic [6:0]  digit_chars [64];
    logic [31:0] mag;
    logic [31:0] digit;
    logic [6:0]  fill_char;
    logic [6:0]  alpha_base;
    int unsigned base;
    int unsigned n_dig;
    int unsigned n_fill;
    int unsigned width;
    int unsigned count;
    bit          negative;
    if (act > iff_pkg::ACT_UHEX) return;
    case (act)
      iff_pkg::ACT_OCT:                   base = 8;
      iff_pkg::ACT_LHEX, iff_pkg::ACT_UHEX: base = 16;
      default:                            base = 10;
    endcase
    alpha_base = (act == iff_pkg::ACT_UHEX) ? CHR_UPPER_A : CHR_LOWER_A;
    negative   = (act == iff_pkg::ACT_SDEC) && val[31];
    mag        = negative ? (~val + 32'd1) : val;
    n_dig      = 0;
    do begin
      digit = mag % base;
      if (digit < 10) begin
        digit_chars[n_dig] = iff_pkg::CH_ZERO + 7'(digit);
      end else begin
        digit_chars[n_dig] = alpha_base + 7'(digit - 10);
      end
      n_dig++;
      mag = mag / base;
    end while (mag != 0 && n_dig < 64);
    width     = (fw > MAX_FIELD) ? MAX_FIELD : fw;
    count     = n_dig + (negative ? 1 : 0);
    n_fill    = (width > count) ? width - count : 0;
    fill_char = zf ? iff_pkg::CH_ZERO : iff_pkg::CH_SPACE;
    if (!lj) for (int i = 0; i < n_fill; i++) push_char(fill_char);
    if (negative) push_char(iff_pkg::CH_MINUS);
    for (int i = n_dig; i > 0; i--) push_char(digit_chars[i - 1]);
    if (lj) for (int i = 0; i < n_fill; i++) push_char(fill_char);
    pending_beats[pending_beats.size() - 1].last = 1'b1;
  endfunction

  // Hold start low with noise on the fields through the gap, then offer the item and wait
  // for the edge that takes it. A gap of zero keeps start high straight into the next item.
  task automatic send_field(input logic [2:0] act, input logic [31:0] val,
                            input logic [6:0] fw, input logic lj, input logic zf,
                            input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start        = 1'b0;
      action       = 3'($urandom);
      value        = $urandom;
      field_width  = 7'($urandom);
      left_justify = 1'($urandom);
      zero_fill    = 1'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start        = 1'b1;
    action       = act;
    value        = val;
    field_width  = fw;
    left_justify = lj;
    zero_fill    = zf;
    do @(posedge clk); while (busy);
    predict_field(act, val, fw, lj, zf);
    if (act > iff_pkg::ACT_UHEX) dropped_sent++;
    else fields_sent++;
  endtask

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 9) return 0;
    if (sel < 17) return $urandom_range(1, 4);
    return $urandom_range(10, 120);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 20);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 20);
      3: return 32'd1 << $urandom_range(0, 31);
      4: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [6:0] pick_width();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 7'($urandom_range(0, 12));
    if (sel < 8) return 7'($urandom_range(8, 24));
    if (sel < 9) return 7'($urandom_range(40, 64));
    return 7'($urandom_range(65, 127));
  endfunction

  // Extremes of value and width across every conversion
  task automatic test_extremes();
    send_field(iff_pkg::ACT_SDEC, 32'h7FFF_FFFF, 7'd0,   1'b0, 1'b0, 0);
    send_field(iff_pkg::ACT_SDEC, 32'hFFFF_FFFF, 7'd0,   1'b0, 1'b0, 1);
    send_field(iff_pkg::ACT_UDEC, 32'hFFFF_FFFF, 7'd64,  1'b0, 1'b1, 0);
    send_field(iff_pkg::ACT_OCT,  32'hFFFF_FFFF, 7'd64,  1'b1, 1'b0, 2);
    send_field(iff_pkg::ACT_LHEX, 32'hDEAD_BEEF, 7'd12,  1'b0, 1'b0, 0);
    send_field(iff_pkg::ACT_UHEX, 32'hDEAD_BEEF, 7'd12,  1'b1, 1'b1, 0);
    send_field(iff_pkg::ACT_LHEX, 32'hABCD_EF01, 7'd127, 1'b0, 1'b0, 3);
    send_field(iff_pkg::ACT_UHEX, 32'h0FED_CBA9, 7'd1,   1'b0, 1'b0, 0);
    send_field(iff_pkg::ACT_OCT,  32'o1234_5670, 7'd3,   1'b1, 1'b1, 0);
  endtask

  // Zero, most negative, zeros before the sign, saturated and undersized widths
  task automatic test_special_cases();
    send_field(iff_pkg::ACT_SDEC, 32'd0,         7'd0,   1'b0, 1'b0, 0);
    send_field(iff_pkg::ACT_LHEX, 32'd0,         7'd5,   1'b1, 1'b0, 0);
    send_field(iff_pkg::ACT_SDEC, 32'h8000_0000, 7'd0,   1'b0, 1'b0, 1);
    send_field(iff_pkg::ACT_SDEC, 32'h8000_0000, 7'd20,  1'b0, 1'b1, 0);
    send_field(iff_pkg::ACT_SDEC, -32'sd5,       7'd5,   1'b0, 1'b1, 0);
    send_field(iff_pkg::ACT_SDEC, -32'sd5,       7'd5,   1'b1, 1'b1, 0);
    send_field(iff_pkg::ACT_SDEC, -32'sd42,      7'd6,   1'b0, 1'b0, 0);
    send_field(iff_pkg::ACT_UDEC, 32'd7,         7'd65,  1'b0, 1'b0, 0);
    send_field(iff_pkg::ACT_UDEC, 32'd123456789, 7'd4,   1'b1, 1'b0, 0);
    send_field(iff_pkg::ACT_SDEC, -32'sd1000,    7'd2,   1'b0, 1'b1, 0);
  endtask

  // Codes above upper hex are taken and dropped without a beat
  task automatic test_unknown_actions();
    send_field(3'd5, 32'hFFFF_FFFF, 7'd64, 1'b0, 1'b1, 0);
    send_field(3'd6, 32'h1234_5678, 7'd10, 1'b1, 1'b0, 0);
    send_field(3'd7, 32'h0000_0000, 7'd0,  1'b0, 1'b0, 1);
    send_field(iff_pkg::ACT_UHEX, 32'h0000_00FF, 7'd0, 1'b0, 1'b0, 0);
  endtask

  // Random fields with mostly short gaps, some long ones and bursts with no gap at all
  task automatic test_random();
    int          burst_left;
    int          gap;
    int          target;
    logic [2:0]  act;
    burst_left = 0;
    target     = fields_sent + FIELDS_RAND;
    while (fields_sent < target) begin
      if (burst_left == 0 && $urandom_range(0, 5) == 0) burst_left = $urandom_range(8, 20);
      if (burst_left > 0) begin
        gap = 0;
        burst_left--;
      end else begin
        gap = pick_gap();
      end
      act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      send_field(act, pick_value(), pick_width(), 1'($urandom), 1'($urandom), gap);
    end
  endtask

  // Compare each strobed beat with the oldest awaited character
  always @(posedge clk) begin
    char_beat_t exp_beat;
    if (!rst && strobe) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat, actual character %h last %b", $time, character, last);
        error_count++;
      end else begin
        exp_beat = pending_beats.pop_front();
        if (character !== exp_beat.character) begin
          $display("%0t: character mismatch, expected %h actual %h",
                   $time, exp_beat.character, character);
          error_count++;
        end
        if (last !== exp_beat.last) begin
          $display("%0t: last mismatch, expected %b actual %b", $time, exp_beat.last, last);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    action       = 3'd0;
    value        = 32'd0;
    field_width  = 7'd0;
    left_justify = 1'b0;
    zero_fill    = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_extremes();
    test_special_cases();
    test_unknown_actions();
    test_random();

    @(negedge clk);
    start = 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    // Catch any stray beat after the final field
    repeat (150) @(posedge clk);

    $display("Formatted %0d fields in all five conversions (%0d dropped codes), %0d beats",
             fields_sent, dropped_sent, beats_seen);
    $display("Widths covered 0 to 127 with both justifications and both fill characters");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
